// ===== src/fcwa_pkg.sv =====
// ----------------------------------------------------------------------------
// fcwa_pkg
// Shared constants for the four-channel window average block.
// ----------------------------------------------------------------------------
package fcwa_pkg;

	localparam int NUM_CH        = 4;
	localparam int SAMPLE_W      = 16;
	localparam int DATA_W        = NUM_CH * SAMPLE_W;
	localparam int WIN_W         = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int DEFAULT_DEPTH = 16;

	localparam logic [WIN_W-1:0] WIN_RESET = 5'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_WINDOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_WINDOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VX_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VY_WINDOW = 3'd3;

endpackage

// ===== src/fcwa_hist_mem.sv =====
// ----------------------------------------------------------------------------
// fcwa_hist_mem
// Sample history store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcwa_hist_mem #(
	parameter int DEPTH = fcwa_pkg::DEFAULT_DEPTH
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [fcwa_pkg::DATA_W-1:0]      wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [fcwa_pkg::DATA_W-1:0]      rd_data
);

	logic [fcwa_pkg::DATA_W-1:0] mem [DEPTH];
	logic [fcwa_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/fcwa_div.sv =====
// ----------------------------------------------------------------------------
// fcwa_div
// Serial divider: signed sum by unsigned count, one quotient bit per cycle,
// truncated toward zero.
// ----------------------------------------------------------------------------
module fcwa_div #(
	parameter int SUM_W = 21,
	parameter int CNT_W = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [SUM_W-1:0]                    dividend,
	input  logic [CNT_W-1:0]                    divisor,
	output logic                                done,
	output logic [fcwa_pkg::SAMPLE_W-1:0]       quot
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;

	logic [CNT_W:0]    shifted;
	logic              fits;
	logic [SUM_W-1:0]  q_full;

	assign shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract where the divisor fits
			if (fits) begin
				rem_q <= shifted - {1'b0, den_q};
			end else begin
				rem_q <= shifted;
			end
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign q_full = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quot   = q_full[fcwa_pkg::SAMPLE_W-1:0];
	assign done   = done_q;

endmodule

// ===== src/four_channel_window_average.sv =====
// ----------------------------------------------------------------------------
// four_channel_window_average
// Moving average of x/y position and x/y velocity over per-channel windows.
// ----------------------------------------------------------------------------
// Flow: a request reads N history entries, where N is the largest clipped
//   window (history reads, one per cycle); the shared serial divider then
//   runs 4 times, on sums of width SUM_W (21 at depth 16).
// One request at a time: the next request is not taken before the result
//   sits in the output register, which waits while m_tready holds it back.
// Reset clears the fill count, write slot and sums, and sets each window to 8.
// ----------------------------------------------------------------------------
module four_channel_window_average #(
	parameter int HISTORY_DEPTH = fcwa_pkg::DEFAULT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// x_position, y_position, x_velocity, y_velocity
	input  logic [fcwa_pkg::DATA_W-1:0]         s_tdata,
	// action
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// smooth_x, smooth_y, smooth_vx, smooth_vy
	output logic [fcwa_pkg::DATA_W-1:0]         m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fcwa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcwa_pkg::WIN_W-1:0]          cfg_data
);

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = fcwa_pkg::SAMPLE_W + CNT_W;
	localparam int CMP_W  = (CNT_W > fcwa_pkg::WIN_W) ? CNT_W : fcwa_pkg::WIN_W;
	localparam int SW     = fcwa_pkg::SAMPLE_W;
	localparam int NCH    = fcwa_pkg::NUM_CH;

	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SUM      = 3'd1;
	localparam logic [2:0] ST_DIV_GO   = 3'd2;
	localparam logic [2:0] ST_DIV_WAIT = 3'd3;
	localparam logic [2:0] ST_PUSH     = 3'd4;

	logic [2:0]                  state_q;
	logic [fcwa_pkg::WIN_W-1:0]  win_q [NCH];
	logic [CNT_W-1:0]            fill_q;
	logic [ADDR_W-1:0]           wr_slot_q;
	logic [ADDR_W-1:0]           rd_addr_q;
	logic [CNT_W-1:0]            rd_cnt_q;
	logic                        rd_vld_s1;
	logic [CNT_W-1:0]            rd_k_s1;
	logic [SUM_W-1:0]            acc_q [NCH];
	logic [SW-1:0]               res_q [NCH];
	logic [1:0]                  ch_q;
	logic                        m_tvalid_q;
	logic [fcwa_pkg::DATA_W-1:0] m_tdata_q;

	logic                        s_accept;
	logic [ADDR_W-1:0]           slot_now;
	logic [CNT_W-1:0]            fill_base;
	logic [CNT_W-1:0]            n_ch [NCH];
	logic [CNT_W-1:0]            max_n;
	logic                        rd_en;
	logic [fcwa_pkg::DATA_W-1:0] rd_data;
	logic                        div_start;
	logic                        div_done;
	logic [SW-1:0]               div_quot;
	logic                        push_ok;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign slot_now  = s_tuser ? '0 : wr_slot_q;
	assign fill_base = s_tuser ? '0 : fill_q;

	// per-channel count: window, at least one, no more than the items held
	always_comb begin
		logic [CMP_W-1:0] w_ext;
		logic [CMP_W-1:0] f_ext;
		for (int c = 0; c < NCH; c++) begin
			w_ext = CMP_W'(win_q[c]);
			f_ext = CMP_W'(fill_q);
			if (w_ext == '0) begin
				w_ext = CMP_W'(1);
			end
			n_ch[c] = (w_ext < f_ext) ? CNT_W'(w_ext) : CNT_W'(f_ext);
		end
	end

	always_comb begin
		max_n = n_ch[0];
		for (int c = 1; c < NCH; c++) begin
			if (n_ch[c] > max_n) begin
				max_n = n_ch[c];
			end
		end
	end

	assign rd_en     = (state_q == ST_SUM) && (rd_cnt_q < max_n);
	assign div_start = (state_q == ST_DIV_GO);
	assign push_ok   = !m_tvalid_q || m_tready;

	fcwa_hist_mem #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist_mem (
		.clk     (clk),
		.wr_en   (s_accept),
		.wr_addr (slot_now),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	fcwa_div #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q[ch_q]),
		.divisor  (n_ch[ch_q]),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				win_q[c] <= fcwa_pkg::WIN_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fcwa_pkg::REG_X_WINDOW:  win_q[0] <= cfg_data;
				fcwa_pkg::REG_Y_WINDOW:  win_q[1] <= cfg_data;
				fcwa_pkg::REG_VX_WINDOW: win_q[2] <= cfg_data;
				fcwa_pkg::REG_VY_WINDOW: win_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			wr_slot_q  <= '0;
			rd_addr_q  <= '0;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_k_s1    <= '0;
			ch_q       <= '0;
			m_tvalid_q <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				acc_q[c] <= '0;
			end
		end else begin
			rd_vld_s1 <= rd_en;
			rd_k_s1   <= rd_cnt_q;
			if (state_q == ST_PUSH && push_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						wr_slot_q <= (slot_now == LAST_SLOT) ? '0 : slot_now + 1'b1;
						fill_q    <= (fill_base == FULL_CNT) ? FULL_CNT : fill_base + 1'b1;
						rd_addr_q <= slot_now;
						rd_cnt_q  <= '0;
						for (int c = 0; c < NCH; c++) begin
							acc_q[c] <= '0;
						end
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// walk back from the newest entry
					if (rd_en) begin
						rd_addr_q <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - 1'b1;
						rd_cnt_q  <= rd_cnt_q + 1'b1;
					end
					if (rd_vld_s1) begin
						for (int c = 0; c < NCH; c++) begin
							if (rd_k_s1 < n_ch[c]) begin
								acc_q[c] <= acc_q[c] + SUM_W'($signed(rd_data[c*SW +: SW]));
							end
						end
					end else if (!rd_en) begin
						ch_q    <= '0;
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						ch_q <= ch_q + 1'b1;
						state_q <= (ch_q == 2'(NCH - 1)) ? ST_PUSH : ST_DIV_GO;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_WAIT && div_done) begin
			res_q[ch_q] <= div_quot;
		end
		if (state_q == ST_PUSH && push_ok) begin
			m_tdata_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above history depth");

	a_fill_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (fill_q != '0) && (state_q == ST_SUM))
		else $error("request did not start a summing pass");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (rd_cnt_q <= max_n) && (max_n != '0))
		else $error("history read count out of range");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_push_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> m_tvalid_q && $stable(m_tdata_q))
		else $error("pending result overwritten");

endmodule
